>>> hw/rtl/pcic_pkg.sv
// Shared types, constants and the control store of the PID regulator.
// No dependencies; imported by every module of the block.
package pcic_pkg;

	localparam int DATA_W    = 32;
	localparam int LIMIT_W   = 31;
	localparam int CFG_IDX_W = 2;
	localparam int PC_W      = 4;
	localparam int FRAC_W    = 16;
	localparam int DIV_W     = DATA_W + FRAC_W;
	localparam int DIV_CNT_W = 6;
	localparam int ACC_W     = 50;
	localparam int MUL_W     = DATA_W + 1;
	localparam int PROD_W    = 2 * MUL_W;

	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP    = 2'd0,
		REG_KI    = 2'd1,
		REG_KD    = 2'd2,
		REG_LIMIT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] measured_value;
		logic signed [DATA_W-1:0] set_point;
		logic        [DATA_W-1:0] time_step;
	} sample_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive_value;
		logic                     drive_saturated;
		logic                     integral_clamped;
	} drive_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_MUL_EDT,
		OP_INTEG,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_END,
		OP_MUL_P,
		OP_MUL_I,
		OP_MUL_D,
		OP_ACC_LOAD,
		OP_ACC_ADD,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_DT_ZERO,
		COND_DIV_MORE
	} cond_t;

	typedef struct packed {
		op_t             op;
		logic            take;
		logic            emit;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		op_t  op;
		logic go;
	} dp_ctrl_t;

	typedef struct packed {
		logic dt_zero;
		logic div_more;
		logic slot_free;
	} dp_stat_t;

	localparam logic [PC_W-1:0] STEP_TAKE     = PC_W'(0);
	localparam logic [PC_W-1:0] STEP_ERR_DT   = PC_W'(1);
	localparam logic [PC_W-1:0] STEP_INTEG    = PC_W'(2);
	localparam logic [PC_W-1:0] STEP_DIV_INIT = PC_W'(3);
	localparam logic [PC_W-1:0] STEP_DIV_LOOP = PC_W'(4);
	localparam logic [PC_W-1:0] STEP_DIV_END  = PC_W'(5);
	localparam logic [PC_W-1:0] STEP_MUL_P    = PC_W'(6);
	localparam logic [PC_W-1:0] STEP_ACC_P    = PC_W'(7);
	localparam logic [PC_W-1:0] STEP_MUL_I    = PC_W'(8);
	localparam logic [PC_W-1:0] STEP_ACC_I    = PC_W'(9);
	localparam logic [PC_W-1:0] STEP_MUL_D    = PC_W'(10);
	localparam logic [PC_W-1:0] STEP_ACC_D    = PC_W'(11);
	localparam logic [PC_W-1:0] STEP_EMIT     = PC_W'(12);

	function automatic ucode_t uc(input op_t op, input logic take, input logic emit,
			input cond_t cond, input logic [PC_W-1:0] target);
		ucode_t w;
		w.op     = op;
		w.take   = take;
		w.emit   = emit;
		w.cond   = cond;
		w.target = target;
		return w;
	endfunction

	// Control store: one word per step
	function automatic ucode_t pcic_ucode(input logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			STEP_TAKE:     w = uc(OP_LOAD,     1'b1, 1'b0, COND_NEXT,     STEP_TAKE);
			STEP_ERR_DT:   w = uc(OP_MUL_EDT,  1'b0, 1'b0, COND_NEXT,     STEP_TAKE);
			STEP_INTEG:    w = uc(OP_INTEG,    1'b0, 1'b0, COND_NEXT,     STEP_TAKE);
			STEP_DIV_INIT: w = uc(OP_DIV_INIT, 1'b0, 1'b0, COND_DT_ZERO,  STEP_MUL_P);
			STEP_DIV_LOOP: w = uc(OP_DIV_STEP, 1'b0, 1'b0, COND_DIV_MORE, STEP_DIV_LOOP);
			STEP_DIV_END:  w = uc(OP_DIV_END,  1'b0, 1'b0, COND_NEXT,     STEP_TAKE);
			STEP_MUL_P:    w = uc(OP_MUL_P,    1'b0, 1'b0, COND_NEXT,     STEP_TAKE);
			STEP_ACC_P:    w = uc(OP_ACC_LOAD, 1'b0, 1'b0, COND_NEXT,     STEP_TAKE);
			STEP_MUL_I:    w = uc(OP_MUL_I,    1'b0, 1'b0, COND_NEXT,     STEP_TAKE);
			STEP_ACC_I:    w = uc(OP_ACC_ADD,  1'b0, 1'b0, COND_NEXT,     STEP_TAKE);
			STEP_MUL_D:    w = uc(OP_MUL_D,    1'b0, 1'b0, COND_NEXT,     STEP_TAKE);
			STEP_ACC_D:    w = uc(OP_ACC_ADD,  1'b0, 1'b0, COND_NEXT,     STEP_TAKE);
			STEP_EMIT:     w = uc(OP_EMIT,     1'b0, 1'b1, COND_ALWAYS,   STEP_TAKE);
			default:       w = uc(OP_NOP,      1'b0, 1'b0, COND_ALWAYS,   STEP_TAKE);
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/pcic_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on pcic_pkg.
module pcic_seq import pcic_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     sample_valid,
	output logic     sample_stall,
	input  dp_stat_t stat,
	output dp_ctrl_t ctrl
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	ucode_t          word;
	logic            go;
	logic            jump;

	assign word = pcic_ucode(pc_q);

	// hold on an input step with no transfer, or an emit step with the slot full
	assign go = !(word.take && !sample_valid) && !(word.emit && !stat.slot_free);

	assign sample_stall = !word.take;
	assign ctrl.op      = word.op;
	assign ctrl.go      = go;

	always_comb begin
		unique case (word.cond)
			COND_NEXT:     jump = 1'b0;
			COND_ALWAYS:   jump = 1'b1;
			COND_DT_ZERO:  jump = stat.dt_zero;
			COND_DIV_MORE: jump = stat.div_more;
			default:       jump = 1'b0;
		endcase
	end

	always_comb begin
		if (!go) begin
			pc_next = pc_q;
		end else if (jump) begin
			pc_next = word.target;
		end else begin
			pc_next = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_TAKE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

>>> hw/rtl/pcic_dp.sv
// Datapath: gain and state registers, shared multiplier, accumulator,
// radix-2 divider step and the output register. Depends on pcic_pkg.
module pcic_dp import pcic_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  sample_t              sample,
	input  dp_ctrl_t             ctrl,
	output dp_stat_t             stat,
	input  logic                 drive_stall,
	output logic                 drive_valid,
	output drive_t               drive
);

	localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic signed [DATA_W-1:0]  kp_q, ki_q, kd_q;
	logic        [LIMIT_W-1:0] limit_q;
	logic signed [DATA_W-1:0]  integ_q;
	logic signed [DATA_W-1:0]  prev_err_q;

	logic signed [DATA_W-1:0]  err_q;
	logic        [DATA_W-1:0]  dt_q;
	logic signed [DATA_W-1:0]  deriv_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic        [DATA_W-1:0]  rem_q;
	logic        [DIV_W-1:0]   divq_q;
	logic [DIV_CNT_W-1:0]      cnt_q;
	logic                      div_neg_q;
	logic                      clamp_q;
	logic                      out_valid_q;
	drive_t                    out_q;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod_full;
	logic signed [ACC_W-1:0]   prod_fl;
	logic signed [DATA_W:0]    err_diff;
	logic signed [DATA_W-1:0]  err_sat;
	logic signed [ACC_W-1:0]   integ_sum, lim_pos, lim_neg;
	logic signed [DATA_W:0]    hist_diff;
	logic        [DATA_W:0]    hist_mag;
	logic        [DATA_W:0]    div_shift;
	logic        [DATA_W+1:0]  div_trial;
	logic                      q_ovf_pos, q_ovf_neg;
	logic signed [DATA_W-1:0]  deriv_new;
	logic                      acc_ovf;
	logic signed [DATA_W-1:0]  acc_sat;
	logic                      slot_free;
	logic                      emit_go;

	// shared multiplier operand select
	always_comb begin
		unique case (ctrl.op)
			OP_MUL_EDT: begin
				mul_a = {err_q[DATA_W-1], err_q};
				mul_b = {1'b0, dt_q};
			end
			OP_MUL_P: begin
				mul_a = {kp_q[DATA_W-1], kp_q};
				mul_b = {err_q[DATA_W-1], err_q};
			end
			OP_MUL_I: begin
				mul_a = {ki_q[DATA_W-1], ki_q};
				mul_b = {integ_q[DATA_W-1], integ_q};
			end
			OP_MUL_D: begin
				mul_a = {kd_q[DATA_W-1], kd_q};
				mul_b = {deriv_q[DATA_W-1], deriv_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_full = mul_a * mul_b;
	assign prod_fl   = ACC_W'(prod_q >>> FRAC_W);

	assign err_diff = (DATA_W+1)'(sample.set_point) - (DATA_W+1)'(sample.measured_value);
	assign err_sat  = (err_diff[DATA_W] != err_diff[DATA_W-1])
		? (err_diff[DATA_W] ? SMIN : SMAX) : err_diff[DATA_W-1:0];

	assign integ_sum = ACC_W'(integ_q) + prod_fl;
	assign lim_pos   = ACC_W'({1'b0, limit_q});
	assign lim_neg   = -lim_pos;

	assign hist_diff = (DATA_W+1)'(err_q) - (DATA_W+1)'(prev_err_q);
	assign hist_mag  = hist_diff[DATA_W] ? (DATA_W+1)'(-hist_diff) : hist_diff;

	assign div_shift = {rem_q, divq_q[DIV_W-1]};
	assign div_trial = {1'b0, div_shift} - {2'b00, dt_q};

	// quotient magnitude against the signed 32-bit range
	assign q_ovf_pos = |divq_q[DIV_W-1:DATA_W-1];
	assign q_ovf_neg = (|divq_q[DIV_W-1:DATA_W])
		|| (divq_q[DATA_W-1] && (|divq_q[DATA_W-2:0]));

	always_comb begin
		if (div_neg_q) begin
			deriv_new = q_ovf_neg ? SMIN : -divq_q[DATA_W-1:0];
		end else begin
			deriv_new = q_ovf_pos ? SMAX : divq_q[DATA_W-1:0];
		end
	end

	assign acc_ovf = !((&acc_q[ACC_W-1:DATA_W-1]) || !(|acc_q[ACC_W-1:DATA_W-1]));
	assign acc_sat = acc_ovf ? (acc_q[ACC_W-1] ? SMIN : SMAX) : acc_q[DATA_W-1:0];

	assign slot_free = !out_valid_q || !drive_stall;
	assign emit_go   = ctrl.go && (ctrl.op == OP_EMIT);

	assign stat.dt_zero   = (dt_q == '0);
	assign stat.div_more  = (cnt_q != DIV_CNT_W'(1));
	assign stat.slot_free = slot_free;

	assign drive_valid = out_valid_q;
	assign drive       = out_q;

	// configuration, loop history and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= '0;
			ki_q        <= '0;
			kd_q        <= '0;
			limit_q     <= '0;
			integ_q     <= '0;
			prev_err_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KP:    kp_q    <= cfg_data;
					REG_KI:    ki_q    <= cfg_data;
					REG_KD:    kd_q    <= cfg_data;
					REG_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
					default:   kp_q    <= kp_q;
				endcase
				integ_q    <= '0;
				prev_err_q <= '0;
			end else if (ctrl.go) begin
				unique case (ctrl.op)
					OP_INTEG: begin
						if (integ_sum > lim_pos) begin
							integ_q <= lim_pos[DATA_W-1:0];
						end else if (integ_sum < lim_neg) begin
							integ_q <= lim_neg[DATA_W-1:0];
						end else begin
							integ_q <= integ_sum[DATA_W-1:0];
						end
					end
					OP_DIV_INIT: prev_err_q <= err_q;
					default: ;
				endcase
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!drive_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctrl.go) begin
			unique case (ctrl.op)
				OP_LOAD: begin
					err_q <= err_sat;
					dt_q  <= sample.time_step;
				end
				OP_MUL_EDT, OP_MUL_P, OP_MUL_I, OP_MUL_D: prod_q <= prod_full;
				OP_INTEG: begin
					clamp_q <= (integ_sum > lim_pos) || (integ_sum < lim_neg);
				end
				OP_DIV_INIT: begin
					div_neg_q <= hist_diff[DATA_W];
					rem_q     <= '0;
					divq_q    <= {hist_mag[DATA_W-1:0], {FRAC_W{1'b0}}};
					cnt_q     <= DIV_STEPS;
					deriv_q   <= '0;
				end
				OP_DIV_STEP: begin
					if (!div_trial[DATA_W+1]) begin
						rem_q <= div_trial[DATA_W-1:0];
					end else begin
						rem_q <= div_shift[DATA_W-1:0];
					end
					divq_q <= {divq_q[DIV_W-2:0], !div_trial[DATA_W+1]};
					cnt_q  <= cnt_q - 1'b1;
				end
				OP_DIV_END:  deriv_q <= deriv_new;
				OP_ACC_LOAD: acc_q   <= prod_fl;
				OP_ACC_ADD:  acc_q   <= acc_q + prod_fl;
				OP_EMIT: begin
					out_q.drive_value      <= acc_sat;
					out_q.drive_saturated  <= acc_ovf;
					out_q.integral_clamped <= clamp_q;
				end
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/pid_controller_integral_clamp_top.sv
// PID regulator, Q16.16, integral clamp. A new item is taken only after the last one has
// passed its emit step, so one item is in flight at a time; the derivative divider runs
// 48 one-bit steps, which are skipped when time_step is zero.
// The output register lets the next item start while a result waits.
// Reset clears gains, limit, integral and last error, and the step counter.
// Depends on pcic_pkg, pcic_seq and pcic_dp.
module pid_controller_integral_clamp_top import pcic_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  sample_t              sample,
	output logic                 drive_valid,
	input  logic                 drive_stall,
	output drive_t               drive
);

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	pcic_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.stat         (stat),
		.ctrl         (ctrl)
	);

	pcic_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample      (sample),
		.ctrl        (ctrl),
		.stat        (stat),
		.drive_stall (drive_stall),
		.drive_valid (drive_valid),
		.drive       (drive)
	);

endmodule

>>> hw/rtl/pcic_chk.sv
// Port-level checks for the PID regulator, bound to the top level.
// Depends on pcic_pkg.
module pcic_chk import pcic_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [DATA_W-1:0]    cfg_data,
	input logic                 sample_valid,
	input logic                 sample_stall,
	input sample_t              sample,
	input logic                 drive_valid,
	input logic                 drive_stall,
	input drive_t               drive
);

	// one item at a time: stall straight after a transfer in
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("input taken twice in a row");

	// a result never appears the cycle after its item arrives
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> !$rose(drive_valid))
		else $error("result too early");

	// a clipped drive sits on a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive.drive_saturated |->
			(drive.drive_value == 32'sh7fffffff || drive.drive_value == 32'sh80000000))
		else $error("saturated drive off the rail");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive_stall |=> drive_valid && $stable(drive))
		else $error("stalled result changed");

endmodule

bind pid_controller_integral_clamp_top pcic_chk u_chk (.*);
